// ----- hw/rtl/ook_remote_pulse_width_transmitter_top_defines.svh -----
// Assertion macros for the OOK pulse-width transmitter checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef OOK_REMOTE_PULSE_WIDTH_TRANSMITTER_TOP_DEFINES_SVH
`define OOK_REMOTE_PULSE_WIDTH_TRANSMITTER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define OOKT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ookt check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define OOKT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ookt check failed");

`endif

// ----- hw/rtl/ookt_pkg.sv -----
// Shared types and constants of the OOK pulse-width transmitter.
// No dependencies; imported by the interfaces, the config file, the core and the top level.
package ookt_pkg;

  localparam int MAX_CODE_BITS = 64;
  localparam int CODE_W        = 64;
  localparam int CNT_W         = 7;
  localparam int REP_W         = 8;
  localparam int TICK_W        = 10;
  localparam int UNIT_W        = 6;
  localparam int POS_W         = 6;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 10;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_START = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_TICKS = 3'd0,
    CFG_SYNC_HIGH  = 3'd1,
    CFG_SYNC_LOW   = 3'd2,
    CFG_ZERO_HIGH  = 3'd3,
    CFG_ZERO_LOW   = 3'd4,
    CFG_ONE_HIGH   = 3'd5,
    CFG_ONE_LOW    = 3'd6
  } cfg_idx_t;

  // Reset values of the configuration registers
  localparam logic [TICK_W-1:0] RST_UNIT_TICKS = 10'd104;
  localparam logic [UNIT_W-1:0] RST_SYNC_HIGH  = 6'd32;
  localparam logic [UNIT_W-1:0] RST_SYNC_LOW   = 6'd33;
  localparam logic [UNIT_W-1:0] RST_ZERO_HIGH  = 6'd4;
  localparam logic [UNIT_W-1:0] RST_ZERO_LOW   = 6'd5;
  localparam logic [UNIT_W-1:0] RST_ONE_HIGH   = 6'd4;
  localparam logic [UNIT_W-1:0] RST_ONE_LOW    = 6'd13;

  // Frame phase, one-hot
  typedef enum logic [3:0] {
    PH_BIT_HIGH  = 4'b0001,
    PH_BIT_LOW   = 4'b0010,
    PH_SYNC_HIGH = 4'b0100,
    PH_SYNC_LOW  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0] unit_ticks;
    logic [UNIT_W-1:0] sync_high_units;
    logic [UNIT_W-1:0] sync_low_units;
    logic [UNIT_W-1:0] zero_high_units;
    logic [UNIT_W-1:0] zero_low_units;
    logic [UNIT_W-1:0] one_high_units;
    logic [UNIT_W-1:0] one_low_units;
  } cfg_t;

  typedef struct packed {
    logic              mode;
    logic [CODE_W-1:0] code_word;
    logic [CNT_W-1:0]  bit_count;
    logic [REP_W-1:0]  repeat_count;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic finished;
  } result_t;

endpackage

// ----- hw/rtl/ookt_ifs.sv -----
// Handshake channel interfaces: input items, results and configuration writes.
// Depends on ookt_pkg for field widths.
interface ookt_in_if import ookt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CODE_W-1:0] code_word;
  logic [CNT_W-1:0]  bit_count;
  logic [REP_W-1:0]  repeat_count;

  modport source (output valid, mode, code_word, bit_count, repeat_count, input ready);
  modport sink   (input valid, mode, code_word, bit_count, repeat_count, output ready);
endinterface

interface ookt_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic finished;

  modport source (output valid, line_level, busy_res, finished, input ready);
  modport sink   (input valid, line_level, busy_res, finished, output ready);
endinterface

interface ookt_cfg_if import ookt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ookt_cfg.sv -----
// Configuration register file of the OOK transmitter: unit length and phase lengths.
// Depends on ookt_pkg and the ookt_cfg_if interface.
module ookt_cfg import ookt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ookt_cfg_if.sink    cfg,
  output cfg_t        regs
);

  logic wr;

  // Always take writes; the user must send them only while the block is idle, which the block does not enforce
  assign cfg.ready = 1'b1;
  assign wr        = cfg.valid && cfg.ready;

  // Decode the index and update at most one register per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.unit_ticks      <= RST_UNIT_TICKS;
      regs.sync_high_units <= RST_SYNC_HIGH;
      regs.sync_low_units  <= RST_SYNC_LOW;
      regs.zero_high_units <= RST_ZERO_HIGH;
      regs.zero_low_units  <= RST_ZERO_LOW;
      regs.one_high_units  <= RST_ONE_HIGH;
      regs.one_low_units   <= RST_ONE_LOW;
    end else if (wr) begin
      unique case (cfg_idx_t'(cfg.index))
        CFG_UNIT_TICKS: regs.unit_ticks      <= cfg.data[TICK_W-1:0];
        CFG_SYNC_HIGH:  regs.sync_high_units <= cfg.data[UNIT_W-1:0];
        CFG_SYNC_LOW:   regs.sync_low_units  <= cfg.data[UNIT_W-1:0];
        CFG_ZERO_HIGH:  regs.zero_high_units <= cfg.data[UNIT_W-1:0];
        CFG_ZERO_LOW:   regs.zero_low_units  <= cfg.data[UNIT_W-1:0];
        CFG_ONE_HIGH:   regs.one_high_units  <= cfg.data[UNIT_W-1:0];
        CFG_ONE_LOW:    regs.one_low_units   <= cfg.data[UNIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/ookt_core.sv -----
// Frame sequencer of the OOK transmitter: code store, bit, frame and time counters.
// Depends on ookt_pkg. Advances by one item when step is high and returns its result.
module ookt_core import ookt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    regs,
  output result_t res
);

  logic [CODE_W-1:0] code_store, code_store_next;
  logic [CNT_W-1:0]  frame_bits, frame_bits_next;
  logic [CNT_W-1:0]  bit_position, bit_position_next;
  logic [REP_W-1:0]  frames_left, frames_left_next;
  phase_t            phase, phase_next;
  logic [TICK_W-1:0] tick_counter, tick_counter_next;
  logic [UNIT_W-1:0] unit_counter, unit_counter_next;
  logic              active, active_next;

  logic [POS_W-1:0]  pos;
  logic              cur_bit;
  logic [UNIT_W-1:0] units;
  logic [TICK_W-1:0] tick_inc;
  logic [UNIT_W-1:0] unit_inc;
  logic [CNT_W-1:0]  nb_sat;
  logic [CNT_W-1:0]  pos_inc;
  logic [REP_W-1:0]  frames_dec;
  logic              done;

  // Select the code bit being sent, first bit at the top of the word
  assign pos     = bit_position[POS_W-1:0];
  assign cur_bit = code_store[POS_W'(CODE_W - 1) - pos];

  // Length of the current phase in units
  always_comb begin
    unique case (phase)
      PH_BIT_HIGH:  units = cur_bit ? regs.one_high_units : regs.zero_high_units;
      PH_BIT_LOW:   units = cur_bit ? regs.one_low_units  : regs.zero_low_units;
      PH_SYNC_HIGH: units = regs.sync_high_units;
      default:      units = regs.sync_low_units;
    endcase
  end

  assign tick_inc   = tick_counter + TICK_W'(1);
  assign unit_inc   = unit_counter + UNIT_W'(1);
  assign pos_inc    = bit_position + CNT_W'(1);
  assign frames_dec = frames_left - REP_W'(1);
  assign nb_sat     = (item.bit_count > CNT_W'(MAX_CODE_BITS)) ?
                      CNT_W'(MAX_CODE_BITS) : item.bit_count;

  // Next state for one accepted transaction
  always_comb begin
    code_store_next   = code_store;
    frame_bits_next   = frame_bits;
    bit_position_next = bit_position;
    frames_left_next  = frames_left;
    phase_next        = phase;
    tick_counter_next = tick_counter;
    unit_counter_next = unit_counter;
    active_next       = active;
    done              = 1'b0;
    if (item.mode == MODE_START) begin
      // Load a new transmission only when idle and frames are requested
      if (!active && item.repeat_count != '0) begin
        code_store_next   = item.code_word;
        frame_bits_next   = nb_sat;
        frames_left_next  = item.repeat_count;
        tick_counter_next = '0;
        unit_counter_next = '0;
        active_next       = 1'b1;
        bit_position_next = '0;
        phase_next        = (nb_sat == '0) ? PH_SYNC_HIGH : PH_BIT_HIGH;
      end
    end else if (active) begin
      // Advance time by one tick, roll over into units and phases
      if (tick_inc == regs.unit_ticks) begin
        tick_counter_next = '0;
        if (unit_inc == units) begin
          unit_counter_next = '0;
          unique case (phase)
            PH_BIT_HIGH: phase_next = PH_BIT_LOW;
            PH_BIT_LOW: begin
              bit_position_next = pos_inc;
              phase_next = (pos_inc >= frame_bits) ? PH_SYNC_HIGH : PH_BIT_HIGH;
            end
            PH_SYNC_HIGH: phase_next = PH_SYNC_LOW;
            default: begin
              frames_left_next  = frames_dec;
              bit_position_next = '0;
              if (frames_dec == '0) begin
                active_next = 1'b0;
                phase_next  = PH_BIT_HIGH;
                done        = 1'b1;
              end else begin
                phase_next = (frame_bits == '0) ? PH_SYNC_HIGH : PH_BIT_HIGH;
              end
            end
          endcase
        end else begin
          unit_counter_next = unit_inc;
        end
      end else begin
        tick_counter_next = tick_inc;
      end
    end
  end

  // Result as seen after this transaction
  assign res.line_level = active_next &&
                          (phase_next == PH_BIT_HIGH || phase_next == PH_SYNC_HIGH);
  assign res.busy_res   = active_next;
  assign res.finished   = done;

  // Commit state on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      code_store   <= '0;
      frame_bits   <= '0;
      bit_position <= '0;
      frames_left  <= '0;
      phase        <= PH_BIT_HIGH;
      tick_counter <= '0;
      unit_counter <= '0;
      active       <= 1'b0;
    end else if (step) begin
      code_store   <= code_store_next;
      frame_bits   <= frame_bits_next;
      bit_position <= bit_position_next;
      frames_left  <= frames_left_next;
      phase        <= phase_next;
      tick_counter <= tick_counter_next;
      unit_counter <= unit_counter_next;
      active       <= active_next;
    end
  end

endmodule

// ----- hw/rtl/ook_remote_pulse_width_transmitter_top.sv -----
// OOK pulse-width remote-control transmitter, top level.
// Depends on ookt_pkg, the channel interfaces, ookt_cfg and ookt_core.
//
// Each input transaction is either a one-microsecond tick or a start of a
// transmission, and gives exactly one result (line level, busy, finished).
// The block takes one transaction per clock cycle while the result channel
// is not stalled. A transaction is held in the input register and its result
// in the result register, with the whole counter and phase update done
// combinationally between them. The input side keeps accepting while a result
// waits, and stalls only when both registers are full.
// Configuration writes are always accepted and apply to the next tick.
module ook_remote_pulse_width_transmitter_top import ookt_pkg::*; (
  input logic         clk,
  input logic         rst,
  ookt_in_if.sink     item,
  ookt_out_if.source  result,
  ookt_cfg_if.sink    cfg
);

  cfg_t    regs;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_advance;
  logic    in_take;
  result_t res;
  result_t out_res;
  logic    out_valid;

  ookt_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ookt_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (s1_advance),
    .item (s1_item),
    .regs (regs),
    .res  (res)
  );

  // Move the held transaction on when the result register is free
  assign s1_advance = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || s1_advance;
  assign in_take    = item.valid && item.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.mode         <= item.mode;
      s1_item.code_word    <= item.code_word;
      s1_item.bit_count    <= item.bit_count;
      s1_item.repeat_count <= item.repeat_count;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res <= res;
    end
  end

  assign result.valid      = out_valid;
  assign result.line_level = out_res.line_level;
  assign result.busy_res   = out_res.busy_res;
  assign result.finished   = out_res.finished;

endmodule

// ----- hw/rtl/ookt_checker.sv -----
// Port-level checks of the OOK transmitter result channel, bound to the top level.
// Depends on the assertion macros in the defines header.
`include "ook_remote_pulse_width_transmitter_top_defines.svh"

module ookt_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic line_level,
  input logic busy_res,
  input logic finished
);

  // An idle line is low
  `OOKT_ASSERT_SAME(a_idle_low, out_valid && !busy_res, !line_level)
  // The end of a transmission leaves the block idle
  `OOKT_ASSERT_SAME(a_done_idle, out_valid && finished, !busy_res && !line_level)
  // Hold a stalled result
  `OOKT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(line_level) && $stable(busy_res) &&
                    $stable(finished))

endmodule

bind ook_remote_pulse_width_transmitter_top ookt_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .line_level (result.line_level),
  .busy_res   (result.busy_res),
  .finished   (result.finished)
);
